// ===== src/graphics_escape_interceptor_defines.svh =====
// ----------------------------------------------------------------------------
// Graphics escape interceptor assertion macros
// Assertion wrappers shared by the interceptor modules; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef GRAPHICS_ESCAPE_INTERCEPTOR_DEFINES_SVH
`define GRAPHICS_ESCAPE_INTERCEPTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define GEI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// check on every clock edge, reset included
`define GEI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);
`else
`define GEI_ASSERT(lbl, prop, msg)
`define GEI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/gei_pkg.sv =====
// ----------------------------------------------------------------------------
// Graphics escape interceptor package
// Byte codes, request format and shared types of the interceptor.
// ----------------------------------------------------------------------------
`default_nettype none

package gei_pkg;

    // control bytes of the escape sequences
    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] APC_INTRO = 8'h5F;
    localparam logic [7:0] DCS_INTRO = 8'h50;
    localparam logic [7:0] APC_FINAL = 8'h47;
    localparam logic [7:0] DCS_FINAL = 8'h71;
    localparam logic [7:0] ST_FINAL  = 8'h5C;

    // default depth of the request queue
    localparam int GEI_QUEUE_DEPTH = 4;

    // prefix bytes held back in text mode
    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_ESC   = 2'd1,
        HELD_INTRO = 2'd2
    } t_held;

    // shape of the result burst one request expands into
    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_PAIR   = 2'd1,
        KIND_TRIPLE = 2'd2
    } t_kind;

    // request from the classifier to the emitter
    typedef struct packed {
        t_kind      kind;
        logic       gfx;
        logic       send;
        logic [7:0] second;
        logic [7:0] data;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/gei_front.sv =====
// ----------------------------------------------------------------------------
// Graphics escape interceptor classifier
// Tracks text/graphics mode and held prefix bytes, queues result requests.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graphics_escape_interceptor_defines.svh"

module gei_front import gei_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic       r_in_graphics, n_in_graphics;
    t_held      r_held, n_held;
    logic [7:0] r_held_second, n_held_second;
    logic       r_prev_was_esc, n_prev_was_esc;
    logic       w_accept;
    logic       w_opens;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_opens  = (r_held_second == APC_INTRO && i_byte == APC_FINAL) ||
                      (r_held_second == DCS_INTRO && i_byte == DCS_FINAL);

    // classify the byte and decide the next mode
    always_comb begin
        n_in_graphics  = r_in_graphics;
        n_held         = r_held;
        n_held_second  = r_held_second;
        n_prev_was_esc = r_prev_was_esc;
        o_push         = 1'b0;
        o_cmd.kind     = KIND_SINGLE;
        o_cmd.gfx      = 1'b0;
        o_cmd.send     = 1'b0;
        o_cmd.second   = r_held_second;
        o_cmd.data     = i_byte;
        if (r_in_graphics) begin
            o_push    = w_accept;
            o_cmd.gfx = 1'b1;
            if (r_prev_was_esc && i_byte == ST_FINAL) begin
                o_cmd.send     = 1'b1;
                n_in_graphics  = 1'b0;
                n_prev_was_esc = 1'b0;
            end else begin
                n_prev_was_esc = (i_byte == ESC_BYTE);
            end
        end else begin
            case (r_held)
                HELD_ESC: begin
                    if (i_byte == APC_INTRO || i_byte == DCS_INTRO) begin
                        n_held_second = i_byte;
                        n_held        = HELD_INTRO;
                    end else begin
                        o_push        = w_accept;
                        o_cmd.kind    = KIND_PAIR;
                        n_held        = HELD_NONE;
                        n_held_second = '0;
                    end
                end
                HELD_INTRO: begin
                    o_push        = w_accept;
                    o_cmd.kind    = KIND_TRIPLE;
                    o_cmd.gfx     = w_opens;
                    n_held        = HELD_NONE;
                    n_held_second = '0;
                    if (w_opens) begin
                        n_in_graphics  = 1'b1;
                        n_prev_was_esc = 1'b0;
                    end
                end
                default: begin
                    if (i_byte == ESC_BYTE) begin
                        n_held = HELD_ESC;
                    end else begin
                        n_held = HELD_NONE;
                        o_push = w_accept;
                    end
                end
            endcase
        end
    end

    // advance the mode on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_graphics  <= 1'b0;
            r_held         <= HELD_NONE;
            r_held_second  <= '0;
            r_prev_was_esc <= 1'b0;
        end else if (w_accept) begin
            r_in_graphics  <= n_in_graphics;
            r_held         <= n_held;
            r_held_second  <= n_held_second;
            r_prev_was_esc <= n_prev_was_esc;
        end
    end

    `GEI_ASSERT(a_gfx_holds_nothing, r_in_graphics |-> r_held == HELD_NONE, "prefix held in graphics mode")

endmodule

`default_nettype wire

// ===== src/gei_queue.sv =====
// ----------------------------------------------------------------------------
// Graphics escape interceptor request queue
// Small show-ahead queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graphics_escape_interceptor_defines.svh"

module gei_queue import gei_pkg::*; #(
    parameter int DEPTH = GEI_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];
    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // store requests
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `GEI_ASSERT(a_fill_bound, r_count <= CW'(DEPTH), "queue fill level beyond depth")
    `GEI_ASSERT(a_pop_nonempty, i_pop |-> !o_empty, "request popped from empty queue")

endmodule

`default_nettype wire

// ===== src/gei_back.sv =====
// ----------------------------------------------------------------------------
// Graphics escape interceptor emitter
// Expands queued requests into one to three results, one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graphics_escape_interceptor_defines.svh"

module gei_back import gei_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [7:0] o_byte,
    output logic       o_gfx,
    output logic       o_end,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_gfx;
    logic       r_end;
    logic       r_last, n_last;
    logic [1:0] r_step;
    logic [1:0] w_final_step;
    logic       w_load;

    // output register free or being drained
    assign w_load = !i_empty && (!r_valid || i_ready);
    assign o_pop  = w_load && n_last;

    // pick the byte for the current step
    always_comb begin
        case (i_cmd.kind)
            KIND_PAIR:   w_final_step = 2'd1;
            KIND_TRIPLE: w_final_step = 2'd2;
            default:     w_final_step = 2'd0;
        endcase
        n_last = (r_step == w_final_step);
        case (r_step)
            2'd0:    n_byte = (i_cmd.kind == KIND_SINGLE) ? i_cmd.data : ESC_BYTE;
            2'd1:    n_byte = (i_cmd.kind == KIND_TRIPLE) ? i_cmd.second : i_cmd.data;
            default: n_byte = i_cmd.data;
        endcase
    end

    // hold the result until taken, advance the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_step  <= n_last ? 2'd0 : r_step + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= n_byte;
            r_gfx  <= i_cmd.gfx;
            r_end  <= i_cmd.send && n_last;
            r_last <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_gfx   = r_gfx;
    assign o_end   = r_end;
    assign o_last  = r_last;

    `GEI_ASSERT(a_step_has_req, r_step != 2'd0 |-> !i_empty, "burst in progress with no request")
    `GEI_ASSERT(a_end_is_gfx_last, r_valid && r_end |-> r_gfx && r_last, "end mark off a final graphics result")

endmodule

`default_nettype wire

// ===== src/graphics_escape_interceptor.sv =====
// ----------------------------------------------------------------------------
// Graphics escape interceptor
// Splits a terminal byte stream into text and graphics results.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one terminal byte per request in tdata.
//   Master stream m_axis carries results: tdata is the forwarded byte,
//   tuser[0] selects the graphics channel, tuser[1] marks the backslash that
//   closes a graphics sequence, tlast marks the last result of an input byte.
//   An input byte yields zero to three results; held ESC prefixes give none
//   until resolved.
//   The first result of a byte is registered in the request queue and then
//   in the output register before it is valid.
//   Throughput: one input byte per cycle while the queue has space and one
//   result per cycle while the receiver is ready; the emitter expands a
//   request into its results one after another, and the request queue
//   (QUEUE_DEPTH entries) takes bytes meanwhile.
//   Reset returns to text mode with nothing held and the queue empty.
//   A stalled receiver holds the current result; the queue fills and then
//   s_axis tready drops until space frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module graphics_escape_interceptor import gei_pkg::*; #(
    parameter int QUEUE_DEPTH = GEI_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      o_m_axis_tuser,   // [0] to_graphics, [1] sequence_end
    output logic            o_m_axis_tlast
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_in_cmd;
    t_cmd w_out_cmd;

    gei_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_in_cmd)
    );

    gei_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_out_cmd),
        .o_empty (w_empty)
    );

    gei_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_out_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_gfx   (o_m_axis_tuser[0]),
        .o_end   (o_m_axis_tuser[1]),
        .o_last  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/graphics_escape_interceptor_check.sv =====
// ----------------------------------------------------------------------------
// Graphics escape interceptor checker
// Watches both streams of the interceptor, expands every accepted input byte
// into the results it must cause and compares each output result, field by
// field, against the oldest result still owed. Counts every mismatch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module graphics_escape_interceptor_check import gei_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,    // [7:0] data_byte
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,    // [7:0] out_byte
    input  wire logic [1:0] i_m_tuser,    // [0] to_graphics, [1] sequence_end
    input  wire logic       i_m_tlast,
    output int              o_pending,
    output int              o_fail_count
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_graphics;
        logic       sequence_end;
        logic       is_last;
    } t_result;

    // results owed by the block, oldest first
    t_result owed_results[$];
    int      error_count = 0;

    // own copy of the interceptor state
    logic       gfx_mode;
    t_held      held_state;
    logic [7:0] held_intro;
    logic       esc_seen;

    assign o_fail_count = error_count;

    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic owe(input logic [7:0] b, input logic gfx, input logic seq_end,
                       input logic lst);
        owed_results.push_back('{out_byte: b, to_graphics: gfx, sequence_end: seq_end,
                                 is_last: lst});
    endtask

    // expand one accepted input byte into the results it causes
    task automatic expand_byte(input logic [7:0] b);
        logic opens;
        if (gfx_mode) begin
            if (esc_seen && b == ST_FINAL) begin
                owe(b, 1'b1, 1'b1, 1'b1);
                gfx_mode = 1'b0;
                esc_seen = 1'b0;
            end else begin
                owe(b, 1'b1, 1'b0, 1'b1);
                esc_seen = (b == ESC_BYTE);
            end
        end else begin
            case (held_state)
                HELD_ESC: begin
                    if (b == APC_INTRO || b == DCS_INTRO) begin
                        held_intro = b;
                        held_state = HELD_INTRO;
                    end else begin
                        owe(ESC_BYTE, 1'b0, 1'b0, 1'b0);
                        owe(b, 1'b0, 1'b0, 1'b1);
                        held_state = HELD_NONE;
                        held_intro = '0;
                    end
                end
                HELD_INTRO: begin
                    opens = (held_intro == APC_INTRO && b == APC_FINAL) ||
                            (held_intro == DCS_INTRO && b == DCS_FINAL);
                    owe(ESC_BYTE, opens, 1'b0, 1'b0);
                    owe(held_intro, opens, 1'b0, 1'b0);
                    owe(b, opens, 1'b0, 1'b1);
                    if (opens) begin
                        gfx_mode = 1'b1;
                        esc_seen = 1'b0;
                    end
                    held_state = HELD_NONE;
                    held_intro = '0;
                end
                default: begin
                    // nothing held: hold an ESC, pass anything else as text
                    if (b == ESC_BYTE) begin
                        held_state = HELD_ESC;
                    end else begin
                        held_state = HELD_NONE;
                        owe(b, 1'b0, 1'b0, 1'b1);
                    end
                end
            endcase
        end
    endtask

    // predict on accepted input, compare on accepted output
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            gfx_mode   = 1'b0;
            held_state = HELD_NONE;
            held_intro = '0;
            esc_seen   = 1'b0;
            owed_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expand_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{out_byte: i_m_tdata, to_graphics: i_m_tuser[0],
                        sequence_end: i_m_tuser[1], is_last: i_m_tlast};
                if (owed_results.size() == 0) begin
                    report_error($sformatf("unexpected result byte %02h", got.out_byte));
                end else begin
                    want = owed_results.pop_front();
                    if (got.out_byte !== want.out_byte)
                        report_error($sformatf("out_byte %02h, want %02h",
                                               got.out_byte, want.out_byte));
                    if (got.to_graphics !== want.to_graphics)
                        report_error($sformatf("to_graphics %b, want %b on byte %02h",
                                               got.to_graphics, want.to_graphics,
                                               want.out_byte));
                    if (got.sequence_end !== want.sequence_end)
                        report_error($sformatf("sequence_end %b, want %b on byte %02h",
                                               got.sequence_end, want.sequence_end,
                                               want.out_byte));
                    if (got.is_last !== want.is_last)
                        report_error($sformatf("last %b, want %b on byte %02h",
                                               got.is_last, want.is_last,
                                               want.out_byte));
                end
            end
        end
        o_pending <= owed_results.size();
    end

endmodule

// ===== bench/graphics_escape_interceptor_test.sv =====
// ----------------------------------------------------------------------------
// Graphics escape interceptor testbench
// Feeds directed escape sequences and then phases of random, mostly
// well-formed text and graphics sequences, with random gaps on both sides,
// a long receiver stall and drain pauses. The checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module graphics_escape_interceptor_test;
    import gei_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 75;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata = '0;
    logic       m_axis_tready = 1'b0;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    int         pending;
    int         fail_count;
    int         cycle_count = 0;

    // bytes waiting to be sent, and the idling bounds of the current phase
    logic [7:0] stim_bytes[$];
    int         send_gap_max = 0;
    int         rx_gap_max = 0;
    bit         rx_hold = 1'b0;

    always #5 i_clk = ~i_clk;

    graphics_escape_interceptor i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser),
        .o_m_axis_tlast  (m_axis_tlast)
    );

    graphics_escape_interceptor_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // mostly any byte, often one of the sequence bytes
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: return ESC_BYTE;
            1: return APC_INTRO;
            2: return DCS_INTRO;
            3: return APC_FINAL;
            4: return DCS_FINAL;
            default: return ST_FINAL;
        endcase
    endfunction

    // queue one random segment: text, a whole graphics sequence, a broken prefix or random bytes
    task automatic add_random_segment();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                n = $urandom_range(1, 6);
                repeat (n) stim_bytes.push_back(8'($urandom_range(0, 255)));
            end
            3, 4, 5: begin
                if ($urandom_range(0, 1))
                    stim_bytes = {stim_bytes, ESC_BYTE, APC_INTRO, APC_FINAL};
                else
                    stim_bytes = {stim_bytes, ESC_BYTE, DCS_INTRO, DCS_FINAL};
                n = $urandom_range(0, 8);
                repeat (n) stim_bytes.push_back(pick_byte());
                stim_bytes = {stim_bytes, ESC_BYTE, ST_FINAL};
            end
            6: begin
                stim_bytes.push_back(ESC_BYTE);
                stim_bytes.push_back($urandom_range(0, 1) ? APC_INTRO : DCS_INTRO);
                stim_bytes.push_back(pick_byte());
            end
            7: begin
                stim_bytes.push_back(ESC_BYTE);
                stim_bytes.push_back(pick_byte());
            end
            default: begin
                n = $urandom_range(1, 5);
                repeat (n) stim_bytes.push_back(pick_byte());
            end
        endcase
    endtask

    // offer one request after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // send every queued byte, then drop valid
    task automatic send_queued();
        while (stim_bytes.size() > 0) send_byte(stim_bytes.pop_front());
        s_axis_tvalid <= 1'b0;
    endtask

    // pause until every owed result has arrived
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // receiver: random gaps per result, one long hold when asked
    initial begin : receiver
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // end the run if it hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** graphics_escape_interceptor: FAILED **");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, both openers, every release path, ESC ESC backslash
        send_gap_max = 3;
        rx_gap_max   = 3;
        stim_bytes = {8'h00, 8'hFF, ST_FINAL,
                      ESC_BYTE, APC_INTRO, APC_FINAL, 8'hFF,
                      ESC_BYTE, ESC_BYTE, ST_FINAL,
                      ESC_BYTE, DCS_INTRO, DCS_FINAL, 8'h00, ESC_BYTE, ST_FINAL,
                      ESC_BYTE, ESC_BYTE,
                      ESC_BYTE, APC_INTRO, 8'h78,
                      ESC_BYTE, DCS_INTRO, APC_FINAL,
                      ESC_BYTE, 8'h58};
        send_queued();
        wait_drained();

        // random phases with different idling, one long receiver hold
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_gap_max = 0; rx_gap_max = 0; end
                1: begin send_gap_max = 7; rx_gap_max = 7; end
                2: begin send_gap_max = 0; rx_gap_max = 7; rx_hold = 1'b1; end
                default: begin send_gap_max = 7; rx_gap_max = 0; end
            endcase
            while (stim_bytes.size() < PHASE_ITEMS) add_random_segment();
            send_queued();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** graphics_escape_interceptor: PASSED **");
        end else begin
            $display("** graphics_escape_interceptor: FAILED **");
        end
        $finish;
    end

endmodule
